/* rtl/core/fdeg_pkg.sv */
// ----------------------------------------------------------------------------
// fdeg_pkg
// Shared types, register indexes, reset values and the luma function of the
// frame difference event generator.
// ----------------------------------------------------------------------------
package fdeg_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int COORD_W    = 13;
	localparam int TIME_W     = 32;
	localparam int LUMA_W     = 16;
	localparam int COUNT_W    = 20;

	localparam logic [CFG_IDX_W-1:0] REG_LUMA_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STRIDE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_CAP      = 2'd3;

	localparam logic [15:0] RST_LUMA_THRESHOLD = 16'd3840;
	localparam logic [7:0]  RST_SAMPLE_STRIDE  = 8'd1;
	localparam logic [13:0] RST_FRAME_WIDTH    = 14'd1920;
	localparam logic [19:0] RST_EVENT_CAP      = 20'd100000;

	// Q8.8 luma weights, 0.299 / 0.587 / 0.114 scaled by 256
	localparam logic [LUMA_W-1:0] LUMA_W_RED   = 16'd77;
	localparam logic [LUMA_W-1:0] LUMA_W_GREEN = 16'd150;
	localparam logic [LUMA_W-1:0] LUMA_W_BLUE  = 16'd29;

	typedef struct packed {
		logic               sample;
		logic               frame_end;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TIME_W-1:0]  rel_time;
	} pos_info_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               polarity;
		logic [TIME_W-1:0]  rel_time;
	} event_t;

	// max value 255 * 256 = 65280, fits in 16 bits
	function automatic logic [LUMA_W-1:0] luma(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		luma = LUMA_W_RED * LUMA_W'(r) + LUMA_W_GREEN * LUMA_W'(g) + LUMA_W_BLUE * LUMA_W'(b);
	endfunction

endpackage

/* rtl/core/fdeg_raster.sv */
// ----------------------------------------------------------------------------
// fdeg_raster
// Raster position tracker: column, row, stride phases and frame base time,
// advanced once per accepted pixel.
// ----------------------------------------------------------------------------
module fdeg_raster import fdeg_pkg::*; #(
	parameter int MAX_WIDTH = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              frame_end,
	input  logic [TIME_W-1:0] now_us,
	input  logic [7:0]        sample_stride,
	input  logic [13:0]       frame_width,
	output pos_info_t         pos
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > 15) ? CW + 1 : 15;

	logic [CW-1:0]      column_q;
	logic [COORD_W-1:0] row_q;
	logic [7:0]         col_phase_q;
	logic [7:0]         row_phase_q;
	logic [TIME_W-1:0]  base_time_q;
	logic               at_start_q;

	logic [7:0]    stride_eff;
	logic [WW-1:0] fw_ext;
	logic [WW-1:0] width_eff;
	logic [WW-1:0] col_inc;
	logic          row_wrap;
	logic [8:0]    cph_inc;
	logic [8:0]    rph_inc;
	logic          cph_wrap;
	logic          rph_wrap;

	always_comb begin
		stride_eff = (sample_stride == 8'd0) ? 8'd1 : sample_stride;
		fw_ext     = WW'(frame_width);
		if (fw_ext == '0) begin
			width_eff = WW'(1);
		end else if (fw_ext > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = fw_ext;
		end
		col_inc  = WW'(column_q) + WW'(1);
		row_wrap = col_inc >= width_eff;
		cph_inc  = {1'b0, col_phase_q} + 9'd1;
		rph_inc  = {1'b0, row_phase_q} + 9'd1;
		cph_wrap = cph_inc >= {1'b0, stride_eff};
		rph_wrap = rph_inc >= {1'b0, stride_eff};
	end

	always_comb begin
		pos.sample    = (col_phase_q == 8'd0) && (row_phase_q == 8'd0);
		pos.frame_end = frame_end;
		pos.x         = COORD_W'(column_q);
		pos.y         = row_q;
		// first pixel of a frame is its own time base
		pos.rel_time  = at_start_q ? '0 : now_us - base_time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_q       <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
			base_time_q <= '0;
			at_start_q  <= 1'b1;
		end else if (accept) begin
			at_start_q <= 1'b0;
			if (at_start_q) begin
				base_time_q <= now_us;
			end
			if (frame_end) begin
				column_q    <= '0;
				row_q       <= '0;
				col_phase_q <= '0;
				row_phase_q <= '0;
				at_start_q  <= 1'b1;
			end else if (row_wrap) begin
				column_q    <= '0;
				col_phase_q <= '0;
				row_q       <= row_q + COORD_W'(1);
				row_phase_q <= rph_wrap ? 8'd0 : rph_inc[7:0];
			end else begin
				column_q    <= CW'(col_inc);
				col_phase_q <= cph_wrap ? 8'd0 : cph_inc[7:0];
			end
		end
	end

endmodule

/* rtl/core/fdeg_detect.sv */
// ----------------------------------------------------------------------------
// fdeg_detect
// Change detector stage: registers the pixel, compares luma of both frames
// against the threshold and keeps the per-frame event count.
// ----------------------------------------------------------------------------
module fdeg_detect import fdeg_pkg::*; #(
	parameter int MAX_EVENTS = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               leave,
	input  pos_info_t          pos,
	input  logic [7:0]         cur_red,
	input  logic [7:0]         cur_green,
	input  logic [7:0]         cur_blue,
	input  logic [7:0]         prev_red,
	input  logic [7:0]         prev_green,
	input  logic [7:0]         prev_blue,
	input  logic [LUMA_W-1:0]  luma_threshold,
	input  logic [COUNT_W-1:0] event_cap,
	output logic               valid_s1,
	output logic               hit,
	output event_t             evt
);

	pos_info_t          pos_s1;
	logic [7:0]         cr_s1, cg_s1, cb_s1;
	logic [7:0]         pr_s1, pg_s1, pb_s1;
	logic [COUNT_W-1:0] events_q;

	logic [LUMA_W-1:0] y_cur;
	logic [LUMA_W-1:0] y_prev;
	logic              brighter;
	logic [LUMA_W-1:0] mag;
	logic              room;

	always_comb begin
		y_cur    = luma(cr_s1, cg_s1, cb_s1);
		y_prev   = luma(pr_s1, pg_s1, pb_s1);
		brighter = y_cur > y_prev;
		mag      = brighter ? y_cur - y_prev : y_prev - y_cur;
		room     = (events_q < event_cap) && (32'(events_q) < 32'(MAX_EVENTS));
		hit      = valid_s1 && pos_s1.sample && (mag > luma_threshold) && room;
		evt.x        = pos_s1.x;
		evt.y        = pos_s1.y;
		evt.polarity = brighter;
		evt.rel_time = pos_s1.rel_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			events_q <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (leave) begin
				valid_s1 <= 1'b0;
			end
			if (leave) begin
				if (pos_s1.frame_end) begin
					events_q <= '0;
				end else if (hit) begin
					events_q <= events_q + COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_s1 <= pos;
			cr_s1  <= cur_red;
			cg_s1  <= cur_green;
			cb_s1  <= cur_blue;
			pr_s1  <= prev_red;
			pg_s1  <= prev_green;
			pb_s1  <= prev_blue;
		end
	end

endmodule

/* rtl/core/frame_difference_event_generator.sv */
// ----------------------------------------------------------------------------
// frame_difference_event_generator
// Emulates an event camera by differencing the luma of two frames.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in channel (valid/ready), each with
// current and previous RGB, a microsecond time and a last-pixel flag. A
// pixel on the stride grid whose luma change exceeds the threshold gives
// one item on the out channel (valid/ready): column, row, polarity and
// time since the first pixel of the frame, up to the frame's event cap.
// Other pixels give nothing. Throughput is one pixel per cycle while the
// output is not stalled. A pixel enters the detect register on accept; its
// event enters the output register once that is free. Registers are written
// through cfg_wr_en / cfg_index / cfg_wdata; the user writes them only while
// the block is idle (not enforced); they take effect from the next pixel.
// When the receiver stalls, the output register holds its event and the
// detect stage holds one more; in_ready drops only once both are full.
// Reset clears position, phases, event count and both stages, loads the
// register defaults, and the next pixel starts a new frame.
// ----------------------------------------------------------------------------
module frame_difference_event_generator import fdeg_pkg::*; #(
	parameter int MAX_WIDTH  = 8192,
	parameter int MAX_EVENTS = 1048576
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            cur_red,
	input  logic [7:0]            cur_green,
	input  logic [7:0]            cur_blue,
	input  logic [7:0]            prev_red,
	input  logic [7:0]            prev_green,
	input  logic [7:0]            prev_blue,
	input  logic [TIME_W-1:0]     now_us,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_W-1:0]    event_x,
	output logic [COORD_W-1:0]    event_y,
	output logic                  polarity,
	output logic [TIME_W-1:0]     rel_time_us
);

	logic [LUMA_W-1:0]  luma_threshold_q;
	logic [7:0]         sample_stride_q;
	logic [13:0]        frame_width_q;
	logic [COUNT_W-1:0] event_cap_q;

	pos_info_t pos;
	event_t    evt;
	event_t    evt_q;
	logic      valid_s1;
	logic      hit;
	logic      accept;
	logic      leave;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_threshold_q <= RST_LUMA_THRESHOLD;
			sample_stride_q  <= RST_SAMPLE_STRIDE;
			frame_width_q    <= RST_FRAME_WIDTH;
			event_cap_q      <= RST_EVENT_CAP;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LUMA_THRESHOLD: luma_threshold_q <= cfg_wdata[15:0];
				REG_SAMPLE_STRIDE:  sample_stride_q  <= cfg_wdata[7:0];
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_wdata[13:0];
				REG_EVENT_CAP:      event_cap_q      <= cfg_wdata[19:0];
			endcase
		end
	end

	// detect stage drains if it has no event or the output register frees up
	assign leave    = valid_s1 && (!hit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || leave;
	assign accept   = in_valid && in_ready;

	fdeg_raster #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.frame_end    (frame_end),
		.now_us       (now_us),
		.sample_stride(sample_stride_q),
		.frame_width  (frame_width_q),
		.pos          (pos)
	);

	fdeg_detect #(
		.MAX_EVENTS(MAX_EVENTS)
	) u_detect (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.leave         (leave),
		.pos           (pos),
		.cur_red       (cur_red),
		.cur_green     (cur_green),
		.cur_blue      (cur_blue),
		.prev_red      (prev_red),
		.prev_green    (prev_green),
		.prev_blue     (prev_blue),
		.luma_threshold(luma_threshold_q),
		.event_cap     (event_cap_q),
		.valid_s1      (valid_s1),
		.hit           (hit),
		.evt           (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (leave && hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave && hit) begin
			evt_q <= evt;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_x     = evt_q.x;
	assign event_y     = evt_q.y;
	assign polarity    = evt_q.polarity;
	assign rel_time_us = evt_q.rel_time;

endmodule

/* rtl/core/fdeg_checker.sv */
// ----------------------------------------------------------------------------
// fdeg_checker
// Port-level checks of the frame difference event generator.
// ----------------------------------------------------------------------------
module fdeg_checker import fdeg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COORD_W-1:0] event_x,
	input logic [COORD_W-1:0] event_y,
	input logic               polarity,
	input logic [TIME_W-1:0]  rel_time_us
);

	// a stalled event holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_x) && $stable(event_y)
			&& $stable(polarity) && $stable(rel_time_us))
		else $error("stalled event changed");

	// nothing on the output right after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("event valid out of reset");

	// a fresh event must follow an accepted item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("event without a matching item");

	// input side keeps moving while the output is empty
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind frame_difference_event_generator fdeg_checker u_fdeg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_x    (event_x),
	.event_y    (event_y),
	.polarity   (polarity),
	.rel_time_us(rel_time_us)
);

/* sim/tb_frame_difference_event_generator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_difference_event_generator
// Self-checking bench for the frame difference event generator. A behavioral
// copy of the block, kept in step with its register settings, predicts the
// event of every accepted pixel; each event leaving the block is compared
// field by field with the oldest prediction. Directed tests cover the
// register defaults, threshold edges, stride and width corner cases, the
// event cap, oversized widths and a long output stall, then random frames
// run under random idling, and a last stretch runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_frame_difference_event_generator;
	import fdeg_pkg::*;

	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 4;
	localparam int MAX_REPORTS      = 40;
	localparam int RANDOM_ITEMS     = 360;
	localparam int LINE_LIMIT       = 8192;
	localparam int FINAL_ITEMS      = 60;

	typedef struct packed {
		logic [7:0]  cur_r;
		logic [7:0]  cur_g;
		logic [7:0]  cur_b;
		logic [7:0]  prev_r;
		logic [7:0]  prev_g;
		logic [7:0]  prev_b;
		logic [31:0] now;
		logic        last;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            cur_red;
	logic [7:0]            cur_green;
	logic [7:0]            cur_blue;
	logic [7:0]            prev_red;
	logic [7:0]            prev_green;
	logic [7:0]            prev_blue;
	logic [TIME_W-1:0]     now_us;
	logic                  frame_end;
	logic                  out_valid;
	logic                  out_ready;
	logic [COORD_W-1:0]    event_x;
	logic [COORD_W-1:0]    event_y;
	logic                  polarity;
	logic [TIME_W-1:0]     rel_time_us;

	// register copies
	logic [15:0] cfg_threshold;
	logic [7:0]  cfg_stride;
	logic [13:0] cfg_width;
	logic [19:0] cfg_cap;

	// position and frame state of the behavioral copy
	logic [12:0] px_col;
	logic [12:0] px_row;
	logic [7:0]  col_phase;
	logic [7:0]  row_phase;
	logic [19:0] frame_events;
	logic [31:0] frame_base;
	logic        frame_fresh;

	event_t      pending_events[$];
	event_t      due_ev;
	pixel_t      seen_px;
	int          error_count = 0;
	int          report_count = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	logic [31:0] clock_us;
	bit          tx_idle_en;
	bit          rx_idle_en;
	bit          long_hold_req;

	frame_difference_event_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cur_red     (cur_red),
		.cur_green   (cur_green),
		.cur_blue    (cur_blue),
		.prev_red    (prev_red),
		.prev_green  (prev_green),
		.prev_blue   (prev_blue),
		.now_us      (now_us),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_x     (event_x),
		.event_y     (event_y),
		.polarity    (polarity),
		.rel_time_us (rel_time_us)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned luma_q88(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return int'(LUMA_W_RED) * int'(r) + int'(LUMA_W_GREEN) * int'(g)
			+ int'(LUMA_W_BLUE) * int'(b);
	endfunction

	function automatic void restart_frame();
		px_col = '0;
		px_row = '0;
		col_phase = '0;
		row_phase = '0;
		frame_events = '0;
		frame_fresh = 1'b1;
	endfunction

	// advances the behavioral copy by one pixel, queueing its event if any
	function automatic void predict_pixel(input pixel_t p);
		int          stride;
		int          width;
		int unsigned y_cur;
		int unsigned y_prev;
		int unsigned mag;
		logic        brighter;
		event_t      ev;
		stride = (cfg_stride == 0) ? 1 : int'(cfg_stride);
		width = (cfg_width == 0) ? 1 : int'(cfg_width);
		if (width > LINE_LIMIT)
			width = LINE_LIMIT;
		if (frame_fresh) begin
			frame_base = p.now;
			frame_fresh = 1'b0;
		end
		if (col_phase == 0 && row_phase == 0) begin
			y_cur = luma_q88(p.cur_r, p.cur_g, p.cur_b);
			y_prev = luma_q88(p.prev_r, p.prev_g, p.prev_b);
			brighter = (y_cur > y_prev);
			mag = brighter ? y_cur - y_prev : y_prev - y_cur;
			// the 20-bit cap always binds before the event ceiling
			if (mag > cfg_threshold && frame_events < cfg_cap) begin
				ev.x = px_col;
				ev.y = px_row;
				ev.polarity = brighter;
				ev.rel_time = p.now - frame_base;
				pending_events = {pending_events, ev};
				frame_events = frame_events + 20'd1;
			end
		end
		if (p.last) begin
			restart_frame();
		end else if (int'(px_col) + 1 >= width) begin
			px_col = '0;
			col_phase = '0;
			px_row = px_row + 13'd1;
			row_phase = (int'(row_phase) + 1 >= stride) ? 8'd0 : row_phase + 8'd1;
		end else begin
			px_col = px_col + 13'd1;
			col_phase = (int'(col_phase) + 1 >= stride) ? 8'd0 : col_phase + 8'd1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (report_count < MAX_REPORTS) begin
				report_count++;
				$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			end
		end
	endfunction

	// prediction on input handshakes, comparison on output handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_px = '{cur_red, cur_green, cur_blue, prev_red, prev_green, prev_blue,
					now_us, frame_end};
				predict_pixel(seen_px);
			end
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					error_count++;
					if (report_count < MAX_REPORTS) begin
						report_count++;
						$display("%0t unexpected event: expected none actual x=%0d y=%0d pol=%0d t=%0h",
							$time, event_x, event_y, polarity, rel_time_us);
					end
				end else begin
					due_ev = pending_events.pop_front();
					check_field("event_x", 32'(due_ev.x), 32'(event_x));
					check_field("event_y", 32'(due_ev.y), 32'(event_y));
					check_field("polarity", 32'(due_ev.polarity), 32'(polarity));
					check_field("rel_time_us", due_ev.rel_time, rel_time_us);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic pixel_t mk_pixel(input logic [23:0] cur, input logic [23:0] prev,
			input logic last);
		pixel_t p;
		{p.cur_r, p.cur_g, p.cur_b} = cur;
		{p.prev_r, p.prev_g, p.prev_b} = prev;
		p.now = clock_us;
		p.last = last;
		clock_us = clock_us + 32'($urandom_range(1, 3));
		return p;
	endfunction

	function automatic pixel_t rand_pixel(input logic last);
		logic [23:0] cur;
		logic [23:0] prev;
		prev = 24'($urandom);
		case ($urandom_range(0, 4))
			0: cur = prev;
			1: cur = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
				{8{$urandom_range(0, 1) == 1}}};
			default: cur = 24'($urandom);
		endcase
		if ($urandom_range(0, 15) == 0)
			clock_us = $urandom;
		return mk_pixel(cur, prev, last);
	endfunction

	task automatic send_pixel(input pixel_t p);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_red <= p.cur_r;
		cur_green <= p.cur_g;
		cur_blue <= p.cur_b;
		prev_red <= p.prev_r;
		prev_green <= p.prev_g;
		prev_blue <= p.prev_b;
		now_us <= p.now;
		frame_end <= p.last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering, let every predicted event out, then cover pixels that gave none
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// upper data bits beyond each register's width are junk on purpose
	task automatic write_config(input logic [15:0] thr, input logic [7:0] stride,
			input logic [13:0] width, input logic [19:0] cap);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_LUMA_THRESHOLD;
		cfg_wdata <= {4'($urandom), thr};
		@(posedge clk);
		cfg_index <= REG_SAMPLE_STRIDE;
		cfg_wdata <= {12'($urandom), stride};
		@(posedge clk);
		cfg_index <= REG_FRAME_WIDTH;
		cfg_wdata <= {6'($urandom), width};
		@(posedge clk);
		cfg_index <= REG_EVENT_CAP;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_threshold = thr;
		cfg_stride = stride;
		cfg_width = width;
		cfg_cap = cap;
	endtask

	task automatic test_reset_defaults();
		// base near the top of the time range so relative times wrap
		clock_us = 32'hFFFF_FFFF;
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b0));
		send_pixel(mk_pixel(24'h808080, 24'h808080, 1'b0));
		send_pixel(mk_pixel(24'h101010, 24'h0F0F0F, 1'b0));
		send_pixel(mk_pixel(24'h00FF00, 24'h000000, 1'b1));
	endtask

	task automatic test_threshold_edge();
		// luma change of this pixel against black is exactly 4640
		write_config(16'd4640, 8'd1, 14'd1920, 20'd100000);
		clock_us = 32'h0000_0000;
		send_pixel(mk_pixel(24'h0A141E, 24'h000000, 1'b0));
		write_config(16'd4639, 8'd1, 14'd1920, 20'd100000);
		send_pixel(mk_pixel(24'h0A141E, 24'h000000, 1'b0));
		write_config(16'hFFFF, 8'd1, 14'd1920, 20'd100000);
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		write_config(16'd0, 8'd1, 14'd1920, 20'd100000);
		send_pixel(mk_pixel(24'h000001, 24'h000000, 1'b0));
		send_pixel(mk_pixel(24'h5A5A5A, 24'h5A5A5A, 1'b1));
	endtask

	task automatic test_stride_and_width();
		// zero stride and zero width behave as one: every pixel its own row
		write_config(16'd0, 8'd0, 14'd0, 20'hFFFFF);
		repeat (3) send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		// mid-frame change leaving a column phase above the new stride
		write_config(16'd0, 8'd4, 14'd8, 20'hFFFFF);
		repeat (3) send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b0));
		write_config(16'd0, 8'd2, 14'd8, 20'hFFFFF);
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b0));
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b1));
		write_config(16'd0, 8'd255, 14'd3, 20'hFFFFF);
		repeat (3) send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b1));
	endtask

	task automatic test_event_cap();
		write_config(16'd0, 8'd1, 14'd4, 20'd0);
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b1));
		// third event of the frame is dropped, the next frame starts counting again
		write_config(16'd0, 8'd1, 14'd4, 20'd2);
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b0));
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b1));
		send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b1));
	endtask

	task automatic test_long_lines();
		// oversized widths saturate; cut to 13 bits they would break these lines early
		write_config(16'd0, 8'd1, 14'h2002, 20'hFFFFF);
		repeat (6) send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b0));
		send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b1));
		write_config(16'd0, 8'd1, 14'h2001, 20'hFFFFF);
		repeat (4) send_pixel(mk_pixel(24'h000000, 24'hFFFFFF, 1'b0));
		send_pixel(mk_pixel(24'hFFFFFF, 24'h000000, 1'b1));
	endtask

	task automatic test_backpressure();
		write_config(16'd0, 8'd1, 14'd6, 20'hFFFFF);
		tx_idle_en = 1'b0;
		long_hold_req = 1'b1;
		for (int i = 1; i <= 40; i++)
			send_pixel(mk_pixel(24'($urandom) | 24'h800000, 24'h000000, i == 40));
		tx_idle_en = 1'b1;
	endtask

	task automatic random_config();
		logic [15:0] thr;
		logic [7:0]  stride;
		logic [13:0] width;
		logic [19:0] cap;
		case ($urandom_range(0, 5))
			0: thr = 16'd0;
			1: thr = 16'hFFFF;
			2: thr = 16'($urandom);
			default: thr = 16'($urandom_range(0, 6000));
		endcase
		case ($urandom_range(0, 7))
			0: stride = 8'd0;
			1: stride = 8'hFF;
			2: stride = 8'($urandom);
			default: stride = 8'($urandom_range(1, 3));
		endcase
		case ($urandom_range(0, 9))
			0: width = 14'd0;
			1: width = 14'd8192;
			2: width = 14'($urandom);
			default: width = 14'($urandom_range(1, 12));
		endcase
		case ($urandom_range(0, 5))
			0: cap = 20'd0;
			1: cap = 20'hFFFFF;
			2: cap = 20'($urandom_range(1, 4));
			default: cap = 20'($urandom);
		endcase
		write_config(thr, stride, width, cap);
	endtask

	task automatic test_random_frames();
		int goal;
		int len;
		int width_eff;
		bit broken;
		goal = items_sent + RANDOM_ITEMS;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		while (items_sent < goal) begin
			random_config();
			width_eff = (cfg_width == 0) ? 1 : int'(cfg_width);
			repeat ($urandom_range(1, 4)) begin
				// mostly whole frames; some end early or run on without an end mark
				broken = ($urandom_range(0, 4) == 0);
				if (broken || width_eff > 16)
					len = $urandom_range(1, 30);
				else
					len = width_eff * $urandom_range(1, 4);
				for (int i = 1; i <= len; i++)
					send_pixel(rand_pixel(i == len && (!broken || $urandom_range(0, 1) == 1)));
			end
		end
	endtask

	task automatic test_no_idle();
		write_config(16'd2000, 8'd1, 14'd5, 20'hFFFFF);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int i = 1; i <= FINAL_ITEMS; i++)
			send_pixel(rand_pixel(i % 15 == 0));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cur_red = '0;
		cur_green = '0;
		cur_blue = '0;
		prev_red = '0;
		prev_green = '0;
		prev_blue = '0;
		now_us = '0;
		frame_end = 1'b0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		long_hold_req = 1'b0;
		clock_us = '0;
		cfg_threshold = RST_LUMA_THRESHOLD;
		cfg_stride = RST_SAMPLE_STRIDE;
		cfg_width = RST_FRAME_WIDTH;
		cfg_cap = RST_EVENT_CAP;
		frame_base = '0;
		restart_frame();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_threshold_edge();
		test_stride_and_width();
		test_event_cap();
		test_long_lines();
		test_backpressure();
		test_random_frames();
		test_no_idle();

		wait_idle();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
